@@ sv/wavp_pkg.sv @@
// ----------------------------------------------------------------------------
// wavp_pkg
// Shared types and codes of the WAV header and chunk parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wavp_pkg;

  // Depth of the queue between the accept side and the parse engine
  localparam int unsigned QueueDepth = 2;

  // Parse status codes
  localparam logic [2:0] StParsing   = 3'd0;
  localparam logic [2:0] StOk        = 3'd1;
  localparam logic [2:0] StNotRiff   = 3'd2;
  localparam logic [2:0] StRiffZero  = 3'd3;
  localparam logic [2:0] StNotWave   = 3'd4;
  localparam logic [2:0] StBadFormat = 3'd5;
  localparam logic [2:0] StMissing   = 3'd6;
  localparam logic [2:0] StUnplay    = 3'd7;

  // Chunk and header tags, little-endian
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  // fmt chunk format tags
  localparam logic [15:0] FmtPcm   = 16'h0001;
  localparam logic [15:0] FmtFloat = 16'h0003;
  localparam logic [15:0] FmtAlaw  = 16'h0006;
  localparam logic [15:0] FmtMulaw = 16'h0007;

  // One accepted file byte with its framing flags
  typedef struct packed {
    logic [7:0] data;
    logic       sof;
    logic       eof;
  } wavp_item_t;

  // One result item: audio byte plus a snapshot of the parse state
  typedef struct packed {
    logic        audio_valid;
    logic [7:0]  audio_byte;
    logic        audio_last;
    logic [2:0]  status;
    logic [63:0] fmt_fields;  // format, channels, block align, bits
    logic [63:0] rates;       // sample rate, byte rate
  } wavp_result_t;

endpackage

@@ sv/wav_header_chunk_parser_top.sv @@
// ----------------------------------------------------------------------------
// wav_header_chunk_parser_top: WAV header check and chunk walk, byte stream.
// One result per byte; an accepted byte passes the queue slot and then the engine's
// result register before its result is valid at the output.
// Throughput 1 byte/cycle while out_ready_i is high; engine steps once a byte.
// Reset clears parse state, queue and result valid; start_of_file restarts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wav_header_chunk_parser_top #(
  parameter int unsigned QueueDepth = wavp_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  file_byte_i,
  input  logic        start_of_file_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        audio_valid_o,
  output logic [7:0]  audio_byte_o,
  output logic        audio_last_o,
  output logic [2:0]  parse_status_o,
  output logic [15:0] format_code_o,
  output logic [15:0] channel_count_o,
  output logic [31:0] sample_rate_o,
  output logic [31:0] byte_rate_o,
  output logic [15:0] block_align_o,
  output logic [15:0] bits_per_sample_o,
  output logic        float_format_o
);

  wavp_pkg::wavp_item_t   in_item, q_item;
  wavp_pkg::wavp_result_t res;
  logic                   q_valid, q_ready;

  assign in_item.data = file_byte_i;
  assign in_item.sof  = start_of_file_i;
  assign in_item.eof  = end_of_file_i;

  wavp_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(in_valid_i),
    .push_ready_o(in_ready_o),
    .push_item_i (in_item),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_item_o  (q_item)
  );

  wavp_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(q_valid),
    .item_ready_o(q_ready),
    .item_i      (q_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (res)
  );

  assign audio_valid_o     = res.audio_valid;
  assign audio_byte_o      = res.audio_byte;
  assign audio_last_o      = res.audio_last;
  assign parse_status_o    = res.status;
  assign format_code_o     = res.fmt_fields[15:0];
  assign channel_count_o   = res.fmt_fields[31:16];
  assign block_align_o     = res.fmt_fields[47:32];
  assign bits_per_sample_o = res.fmt_fields[63:48];
  assign sample_rate_o     = res.rates[31:0];
  assign byte_rate_o       = res.rates[63:32];
  assign float_format_o    = (res.fmt_fields[15:0] == wavp_pkg::FmtFloat);

`ifndef SYNTHESIS
  // Audio never comes out after a header or format failure
  a_audio_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && audio_valid_o) |->
      (parse_status_o != wavp_pkg::StNotRiff) && (parse_status_o != wavp_pkg::StRiffZero) &&
      (parse_status_o != wavp_pkg::StNotWave) && (parse_status_o != wavp_pkg::StBadFormat))
    else $error("audio byte with a failed parse status");

  a_last_needs_audio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && audio_last_o) |-> audio_valid_o)
    else $error("audio_last without audio_valid");

  // A full queue always offers an item to the engine
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("queue refuses input while empty");
`endif

endmodule

@@ sv/wavp_fifo.sv @@
// ----------------------------------------------------------------------------
// wavp_fifo
// Accept side of the parser: a short item queue that decouples the input
// handshake from the parse engine. Depth must be at least 2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wavp_fifo #(
  parameter int unsigned Depth = wavp_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  wavp_pkg::wavp_item_t push_item_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output wavp_pkg::wavp_item_t pop_item_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  wavp_pkg::wavp_item_t slots_q [Depth];
  logic [AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push, pop;

  assign push_ready_o = (count_q < CW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = slots_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wptr_q] <= push_item_i;
    end
  end

endmodule

@@ sv/wavp_engine.sv @@
// ----------------------------------------------------------------------------
// wavp_engine
// Parse engine: walks the RIFF header and chunks one byte per cycle while the
// result is taken, and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wavp_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  output logic                  item_ready_o,
  input  wavp_pkg::wavp_item_t  item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output wavp_pkg::wavp_result_t result_o
);

  localparam logic [2:0] PhRiff  = 3'd0;
  localparam logic [2:0] PhRsize = 3'd1;
  localparam logic [2:0] PhWave  = 3'd2;
  localparam logic [2:0] PhTag   = 3'd3;
  localparam logic [2:0] PhSize  = 3'd4;
  localparam logic [2:0] PhBody  = 3'd5;
  localparam logic [2:0] PhPad   = 3'd6;
  localparam logic [2:0] PhFinal = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] left_q, left_d;
  logic        have_fmt_q, have_fmt_d;
  logic        have_data_q, have_data_d;
  logic [63:0] fields_q, fields_d;
  logic [63:0] rates_q, rates_d;
  logic [2:0]  status_q, status_d;
  logic [4:0]  fidx_q, fidx_d;
  logic        pad_q, pad_d;

  logic                   out_valid_q;
  wavp_pkg::wavp_result_t res_q, res_d;
  logic                   take;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign take         = item_valid_i && item_ready_o;
  assign out_valid_o  = out_valid_q;
  assign result_o     = res_q;

  // Status once both fmt and data are known, if nothing failed before
  function automatic logic [2:0] both_status(logic hf, logic hd, logic [2:0] st,
                                             logic [15:0] fc);
    logic [2:0] r;
    r = st;
    if (hf && hd && (st == wavp_pkg::StParsing)) begin
      r = ((fc == wavp_pkg::FmtAlaw) || (fc == wavp_pkg::FmtMulaw)) ?
          wavp_pkg::StUnplay : wavp_pkg::StOk;
    end
    return r;
  endfunction

  function automatic logic fmt_known(logic [15:0] fc);
    return (fc == wavp_pkg::FmtPcm) || (fc == wavp_pkg::FmtFloat) ||
           (fc == wavp_pkg::FmtAlaw) || (fc == wavp_pkg::FmtMulaw);
  endfunction

  always_comb begin
    logic [31:0] word;
    logic [31:0] left_dec;
    logic [4:0]  sub;

    phase_d     = phase_q;
    idx_d       = idx_q;
    shift_d     = shift_q;
    tag_d       = tag_q;
    left_d      = left_q;
    have_fmt_d  = have_fmt_q;
    have_data_d = have_data_q;
    fields_d    = fields_q;
    rates_d     = rates_q;
    status_d    = status_q;
    fidx_d      = fidx_q;
    pad_d       = pad_q;
    res_d       = res_q;
    word        = '0;
    left_dec    = '0;
    sub         = '0;

    if (take) begin
      res_d.audio_valid = 1'b0;
      res_d.audio_byte  = '0;
      res_d.audio_last  = 1'b0;

      // Restart: this byte is offset zero
      if (item_i.sof) begin
        phase_d     = PhRiff;
        idx_d       = '0;
        shift_d     = '0;
        tag_d       = '0;
        left_d      = '0;
        have_fmt_d  = 1'b0;
        have_data_d = 1'b0;
        fields_d    = '0;
        rates_d     = '0;
        status_d    = wavp_pkg::StParsing;
        fidx_d      = '0;
        pad_d       = 1'b0;
      end

      if (phase_d != PhFinal) begin
        if (phase_d <= PhSize) begin
          word    = {item_i.data, shift_d[31:8]};
          shift_d = word;
          if (idx_d == 2'd3) begin
            idx_d = '0;
            unique case (phase_d)
              PhRiff: begin
                if (word != wavp_pkg::TagRiff) begin
                  status_d = wavp_pkg::StNotRiff;
                  phase_d  = PhFinal;
                end else begin
                  phase_d = PhRsize;
                end
              end
              PhRsize: begin
                if (word == '0) begin
                  status_d = wavp_pkg::StRiffZero;
                  phase_d  = PhFinal;
                end else begin
                  phase_d = PhWave;
                end
              end
              PhWave: begin
                if (word != wavp_pkg::TagWave) begin
                  status_d = wavp_pkg::StNotWave;
                  phase_d  = PhFinal;
                end else begin
                  phase_d = PhTag;
                end
              end
              PhTag: begin
                tag_d   = word;
                phase_d = PhSize;
              end
              default: begin
                left_d  = word;
                pad_d   = word[0];
                phase_d = PhBody;
                if ((tag_d == wavp_pkg::TagFmt) && !have_fmt_d) begin
                  fields_d = '0;
                  rates_d  = '0;
                  fidx_d   = '0;
                  if (word == '0) begin
                    // Empty fmt body: format tag reads as zero
                    have_fmt_d = 1'b1;
                    status_d   = wavp_pkg::StBadFormat;
                    phase_d    = PhFinal;
                  end
                end else if (tag_d == wavp_pkg::TagData) begin
                  have_data_d = 1'b1;
                  status_d    = both_status(have_fmt_d, 1'b1, status_d, fields_d[15:0]);
                end
                if ((phase_d == PhBody) && (word == '0)) begin
                  phase_d = (status_d != wavp_pkg::StParsing) ? PhFinal :
                            (pad_d ? PhPad : PhTag);
                end else if ((phase_d == PhBody) && (status_d != wavp_pkg::StParsing) &&
                             (tag_d != wavp_pkg::TagData)) begin
                  phase_d = PhFinal;
                end
              end
            endcase
          end else begin
            idx_d = idx_d + 2'd1;
          end
        end else if (phase_d == PhBody) begin
          left_dec = left_d - 32'd1;
          left_d   = left_dec;
          if (tag_d == wavp_pkg::TagData) begin
            res_d.audio_valid = 1'b1;
            res_d.audio_byte  = item_i.data;
            res_d.audio_last  = (left_dec == '0) || item_i.eof;
            if (left_dec == '0) begin
              phase_d = (status_d != wavp_pkg::StParsing) ? PhFinal :
                        (pad_d ? PhPad : PhTag);
            end
          end else if ((tag_d == wavp_pkg::TagFmt) && !have_fmt_d) begin
            // Capture the byte at its place in the fmt body
            if (fidx_d < 5'd4) begin
              fields_d[{fidx_d[1:0], 3'b000} +: 8] = item_i.data;
            end else if (fidx_d < 5'd12) begin
              sub = fidx_d - 5'd4;
              rates_d[{sub[2:0], 3'b000} +: 8] = item_i.data;
            end else if (fidx_d < 5'd16) begin
              fields_d[{1'b1, fidx_d[1:0], 3'b000} +: 8] = item_i.data;
            end
            fidx_d = fidx_d + 5'd1;
            if (fidx_d[4] || (left_dec == '0)) begin
              have_fmt_d = 1'b1;
              if (!fmt_known(fields_d[15:0])) begin
                status_d = wavp_pkg::StBadFormat;
                phase_d  = PhFinal;
              end else begin
                status_d = both_status(1'b1, have_data_d, status_d, fields_d[15:0]);
                if (status_d != wavp_pkg::StParsing) begin
                  phase_d = PhFinal;
                end else if (left_dec == '0) begin
                  phase_d = pad_d ? PhPad : PhTag;
                end
              end
            end
          end else if (left_dec == '0) begin
            phase_d = (status_d != wavp_pkg::StParsing) ? PhFinal :
                      (pad_d ? PhPad : PhTag);
          end
        end else begin
          // Drop the pad byte after an odd-sized body
          phase_d = PhTag;
        end

        if (item_i.eof && (phase_d != PhFinal)) begin
          if (status_d == wavp_pkg::StParsing) begin
            status_d = wavp_pkg::StMissing;
          end
          phase_d = PhFinal;
        end
      end

      res_d.status     = status_d;
      res_d.fmt_fields = fields_d;
      res_d.rates      = rates_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhRiff;
      idx_q       <= '0;
      shift_q     <= '0;
      tag_q       <= '0;
      left_q      <= '0;
      have_fmt_q  <= 1'b0;
      have_data_q <= 1'b0;
      fields_q    <= '0;
      rates_q     <= '0;
      status_q    <= wavp_pkg::StParsing;
      fidx_q      <= '0;
      pad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      shift_q     <= shift_d;
      tag_q       <= tag_d;
      left_q      <= left_d;
      have_fmt_q  <= have_fmt_d;
      have_data_q <= have_data_d;
      fields_q    <= fields_d;
      rates_q     <= rates_d;
      status_q    <= status_d;
      fidx_q      <= fidx_d;
      pad_q       <= pad_d;
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule
